/* rtl/cart_pkg.sv */
package cart_pkg;

  // Item kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;

  // Vehicle command codes
  localparam logic [3:0] VC_ARM     = 4'd1;
  localparam logic [3:0] VC_DISARM  = 4'd2;
  localparam logic [3:0] VC_TAKEOFF = 4'd3;
  localparam logic [3:0] VC_AUTO    = 4'd4;
  localparam logic [3:0] VC_RTL     = 4'd5;
  localparam logic [3:0] VC_LOITER  = 4'd6;
  localparam logic [3:0] VC_LAND    = 4'd7;

  // Block reasons
  localparam logic [2:0] BR_NONE        = 3'd0;
  localparam logic [2:0] BR_FAILSAFE    = 3'd1;
  localparam logic [2:0] BR_NOT_ARMED   = 3'd2;
  localparam logic [2:0] BR_NOT_LANDED  = 3'd3;
  localparam logic [2:0] BR_UNSUPPORTED = 3'd4;
  localparam logic [2:0] BR_PREFLIGHT   = 3'd5;
  localparam logic [2:0] BR_BUSY        = 3'd6;
  localparam logic [2:0] BR_NO_SENDER   = 3'd7;

  // Acknowledgement result codes
  localparam logic [7:0] RES_ACCEPTED     = 8'd0;
  localparam logic [7:0] RES_TEMP_REJECT  = 8'd1;
  localparam logic [7:0] RES_DENIED       = 8'd2;
  localparam logic [7:0] RES_UNSUPPORTED  = 8'd3;
  localparam logic [7:0] RES_FAILED       = 8'd4;
  localparam logic [7:0] RES_IN_PROGRESS  = 8'd5;

  // Command ids on the wire
  localparam logic [15:0] ID_ARM_DISARM = 16'd400;
  localparam logic [15:0] ID_SET_MODE   = 16'd176;
  localparam logic [15:0] ID_RTL        = 16'd20;
  localparam logic [15:0] ID_LOITER     = 16'd17;
  localparam logic [15:0] ID_TAKEOFF    = 16'd22;
  localparam logic [15:0] ID_LAND       = 16'd21;

  // Register indexes
  localparam logic [1:0] REG_SENDER_BOUND = 2'd0;
  localparam logic [1:0] REG_SIM_MODE     = 2'd1;
  localparam logic [1:0] REG_ACK_TIMEOUT  = 2'd2;
  localparam logic [1:0] REG_RETRY_LIMIT  = 2'd3;

  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd5000;
  localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd5;
  localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

  typedef struct packed {
    logic        sender_bound;
    logic        sim_mode;
    logic [15:0] ack_timeout_ms;
    logic [3:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic        active;
    logic [3:0]  logical_command;
    logic [15:0] wire_command_id;
    logic [3:0]  retry_counter;
    logic [15:0] elapsed_ms;
    logic        gave_up;
    logic        arm_ack_seen;
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  vehicle_cmd;
    logic        failsafe;
    logic        preflight_ready;
    logic        armed;
    logic        landed;
    logic [15:0] ack_command_id;
    logic [7:0]  ack_result;
  } item_t;

  typedef struct packed {
    logic        request_accepted;
    logic [2:0]  reject_code;
    logic        send_valid;
    logic        send_is_arm;
    logic [15:0] send_command_id;
    logic        busy_res;
    logic        failed_flag;
    logic        arm_acked;
    logic        go_connected;
    logic [3:0]  retries_used;
  } result_t;

  function automatic logic [15:0] map_id(input logic [3:0] vc);
    logic [15:0] id;
    unique case (vc)
      VC_ARM, VC_DISARM: id = ID_ARM_DISARM;
      VC_TAKEOFF:        id = ID_TAKEOFF;
      VC_AUTO:           id = ID_SET_MODE;
      VC_RTL:            id = ID_RTL;
      VC_LOITER:         id = ID_LOITER;
      VC_LAND:           id = ID_LAND;
      default:           id = 16'd0;
    endcase
    return id;
  endfunction

endpackage

/* rtl/cart_cfg.sv */
module cart_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cart_pkg::cfg_t    cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sender_bound   <= 1'b1;
      cfg.sim_mode       <= 1'b0;
      cfg.ack_timeout_ms <= cart_pkg::ACK_TIMEOUT_RESET;
      cfg.retry_limit    <= cart_pkg::RETRY_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        cart_pkg::REG_SENDER_BOUND: cfg.sender_bound   <= pwdata[0];
        cart_pkg::REG_SIM_MODE:     cfg.sim_mode       <= pwdata[0];
        cart_pkg::REG_ACK_TIMEOUT:  cfg.ack_timeout_ms <= pwdata[15:0];
        cart_pkg::REG_RETRY_LIMIT:  cfg.retry_limit    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cart_pkg::REG_SENDER_BOUND: prdata = {31'd0, cfg.sender_bound};
      cart_pkg::REG_SIM_MODE:     prdata = {31'd0, cfg.sim_mode};
      cart_pkg::REG_ACK_TIMEOUT:  prdata = {16'd0, cfg.ack_timeout_ms};
      cart_pkg::REG_RETRY_LIMIT:  prdata = {28'd0, cfg.retry_limit};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/cart_eval.sv */
module cart_eval (
  input  cart_pkg::cfg_t    cfg,
  input  cart_pkg::state_t  st,
  input  cart_pkg::item_t   item,
  output cart_pkg::state_t  st_next,
  output cart_pkg::result_t res
);

  logic [2:0]  reason;
  logic        ok;
  logic [15:0] elapsed_inc;

  // Per-command gate, failsafe first
  always_comb begin
    ok     = 1'b0;
    reason = cart_pkg::BR_NONE;
    if (item.failsafe) begin
      reason = cart_pkg::BR_FAILSAFE;
    end else begin
      unique case (item.vehicle_cmd)
        cart_pkg::VC_ARM: begin
          if (!cfg.sim_mode && !item.preflight_ready) reason = cart_pkg::BR_PREFLIGHT;
          else ok = 1'b1;
        end
        // disarm while not armed is refused with no reason
        cart_pkg::VC_DISARM: ok = item.armed;
        cart_pkg::VC_TAKEOFF: begin
          if (!item.armed)       reason = cart_pkg::BR_NOT_ARMED;
          else if (!item.landed) reason = cart_pkg::BR_NOT_LANDED;
          else                   ok = 1'b1;
        end
        cart_pkg::VC_AUTO: ok = 1'b1;
        cart_pkg::VC_RTL, cart_pkg::VC_LOITER, cart_pkg::VC_LAND: begin
          if (!item.armed) reason = cart_pkg::BR_NOT_ARMED;
          else             ok = 1'b1;
        end
        default: reason = cart_pkg::BR_UNSUPPORTED;
      endcase
    end
  end

  assign elapsed_inc = (st.elapsed_ms == cart_pkg::ELAPSED_MAX) ? st.elapsed_ms
                                                                : st.elapsed_ms + 16'd1;

  always_comb begin
    st_next = st;
    res     = '0;
    unique case (item.cmd)
      cart_pkg::KIND_REQUEST: begin
        if (st.active) begin
          res.reject_code = cart_pkg::BR_BUSY;
        end else if (!cfg.sender_bound) begin
          res.reject_code = cart_pkg::BR_NO_SENDER;
        end else if (ok) begin
          res.request_accepted    = 1'b1;
          res.send_valid          = 1'b1;
          res.send_is_arm         = (item.vehicle_cmd == cart_pkg::VC_ARM);
          res.send_command_id     = cart_pkg::map_id(item.vehicle_cmd);
          st_next.active          = 1'b1;
          st_next.logical_command = item.vehicle_cmd;
          st_next.wire_command_id = cart_pkg::map_id(item.vehicle_cmd);
          st_next.retry_counter   = 4'd0;
          st_next.elapsed_ms      = 16'd0;
          st_next.gave_up         = 1'b0;
        end else begin
          res.reject_code = reason;
        end
      end
      cart_pkg::KIND_ACK: begin
        if (st.active && item.ack_command_id == st.wire_command_id) begin
          unique case (item.ack_result)
            cart_pkg::RES_ACCEPTED: begin
              if (st.logical_command == cart_pkg::VC_ARM) st_next.arm_ack_seen = 1'b1;
              res.go_connected = (st.logical_command == cart_pkg::VC_DISARM);
              st_next.active   = 1'b0;
            end
            cart_pkg::RES_TEMP_REJECT, cart_pkg::RES_IN_PROGRESS: ;
            cart_pkg::RES_DENIED, cart_pkg::RES_UNSUPPORTED, cart_pkg::RES_FAILED: begin
              st_next.active  = 1'b0;
              st_next.gave_up = 1'b1;
            end
            default: st_next.active = 1'b0;
          endcase
        end
      end
      cart_pkg::KIND_TICK: begin
        if (st.active) begin
          st_next.elapsed_ms = elapsed_inc;
          if (cfg.sender_bound && elapsed_inc >= cfg.ack_timeout_ms) begin
            if (st.retry_counter >= cfg.retry_limit) begin
              st_next.gave_up = 1'b1;
              st_next.active  = 1'b0;
            end else begin
              // resend goes out as a plain command, arm included
              st_next.retry_counter = st.retry_counter + 4'd1;
              st_next.elapsed_ms    = 16'd0;
              res.send_valid        = 1'b1;
              res.send_command_id   = st.wire_command_id;
            end
          end
        end
      end
      default: ;
    endcase
    res.busy_res     = st_next.active;
    res.failed_flag  = st_next.gave_up;
    res.arm_acked    = st_next.arm_ack_seen;
    res.retries_used = st_next.active ? st_next.retry_counter : 4'd0;
  end

endmodule

/* rtl/command_ack_retry_tracker_core.sv */
// Channel | valid     | stall     | words
// in      | in_valid  | in_stall  | cmd, vehicle_cmd, flags, ack_command_id, ack_result
// out     | out_valid | out_stall | request_accepted .. retries_used, one per input word
// cfg     | APB: psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One word per cycle while neither side is stalled. A word is taken into the input register,
// then evaluated against the tracker state and written to the result register, which
// drives out_valid.
// rst is synchronous: state clears, configuration returns to its defaults.
// With the result register held by out_stall the input register still takes
// one word; in_stall rises only when both are full.
module command_ack_retry_tracker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [3:0]  vehicle_cmd,
  input  logic        failsafe,
  input  logic        preflight_ready,
  input  logic        armed,
  input  logic        landed,
  input  logic [15:0] ack_command_id,
  input  logic [7:0]  ack_result,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        request_accepted,
  output logic [2:0]  reject_code,
  output logic        send_valid,
  output logic        send_is_arm,
  output logic [15:0] send_command_id,
  output logic        busy_res,
  output logic        failed_flag,
  output logic        arm_acked,
  output logic        go_connected,
  output logic [3:0]  retries_used,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cart_pkg::cfg_t    cfg;
  cart_pkg::state_t  st;
  cart_pkg::state_t  st_next;
  cart_pkg::item_t   item;
  cart_pkg::result_t res_next;
  cart_pkg::result_t res;
  logic              item_valid;
  logic              advance;

  cart_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cart_eval u_eval (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  // Hold the input word while the result side is blocked
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.cmd             <= cmd;
      item.vehicle_cmd     <= vehicle_cmd;
      item.failsafe        <= failsafe;
      item.preflight_ready <= preflight_ready;
      item.armed           <= armed;
      item.landed          <= landed;
      item.ack_command_id  <= ack_command_id;
      item.ack_result      <= ack_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
      if (item_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      res <= res_next;
    end
  end

  assign request_accepted = res.request_accepted;
  assign reject_code      = res.reject_code;
  assign send_valid       = res.send_valid;
  assign send_is_arm      = res.send_is_arm;
  assign send_command_id  = res.send_command_id;
  assign busy_res         = res.busy_res;
  assign failed_flag      = res.failed_flag;
  assign arm_acked        = res.arm_acked;
  assign go_connected     = res.go_connected;
  assign retries_used     = res.retries_used;

endmodule

/* rtl/cart_checker.sv */
module cart_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        request_accepted,
  input logic [2:0]  reject_code,
  input logic        send_valid,
  input logic        send_is_arm,
  input logic [15:0] send_command_id,
  input logic        busy_res,
  input logic        go_connected,
  input logic [3:0]  retries_used
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(send_command_id) && $stable(busy_res))
    else $error("stalled result word changed");

  a_accept_sends: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_accepted |-> send_valid && busy_res
                                      && reject_code == cart_pkg::BR_NONE)
    else $error("accepted request without transmission");

  a_blocked_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && reject_code != cart_pkg::BR_NONE |-> !request_accepted && !send_valid)
    else $error("blocked request transmitted");

  a_idle_retries: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> retries_used == 4'd0 && !send_valid)
    else $error("retries or send reported while idle");

  a_arm_msg: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_is_arm |-> request_accepted
                                 && send_command_id == cart_pkg::ID_ARM_DISARM && !go_connected)
    else $error("arm message flag inconsistent");

endmodule

bind command_ack_retry_tracker_core cart_checker u_cart_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .request_accepted (request_accepted),
  .reject_code      (reject_code),
  .send_valid       (send_valid),
  .send_is_arm      (send_is_arm),
  .send_command_id  (send_command_id),
  .busy_res         (busy_res),
  .go_connected     (go_connected),
  .retries_used     (retries_used)
);

/* sim/command_ack_retry_tracker_core_test.sv */
`timescale 1ns / 100ps

module command_ack_retry_tracker_core_test;

  localparam logic [3:0] F_FS     = 4'b1000;
  localparam logic [3:0] F_READY  = 4'b0100;
  localparam logic [3:0] F_ARMED  = 4'b0010;
  localparam logic [3:0] F_LANDED = 4'b0001;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [3:0] VC_NONE     = 4'd0;
  localparam logic [3:0] VC_SET_HOME = 4'd8;
  localparam logic [3:0] VC_TOP      = 4'd15;

  localparam logic [7:0] RES_CANCELLED        = 8'd6;
  localparam logic [7:0] RES_WRONG_FORM_INT   = 8'd7;
  localparam logic [7:0] RES_WRONG_FORM_FRAME = 8'd8;
  localparam logic [7:0] RES_TOP              = 8'd255;

  localparam int SETTLE_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  cart_pkg::item_t   in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              request_accepted;
  logic [2:0]        reject_code;
  logic              send_valid;
  logic              send_is_arm;
  logic [15:0]       send_command_id;
  logic              busy_res;
  logic              failed_flag;
  logic              arm_acked;
  logic              go_connected;
  logic [3:0]        retries_used;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  command_ack_retry_tracker_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (in_word.cmd),
    .vehicle_cmd      (in_word.vehicle_cmd),
    .failsafe         (in_word.failsafe),
    .preflight_ready  (in_word.preflight_ready),
    .armed            (in_word.armed),
    .landed           (in_word.landed),
    .ack_command_id   (in_word.ack_command_id),
    .ack_result       (in_word.ack_result),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .request_accepted (request_accepted),
    .reject_code      (reject_code),
    .send_valid       (send_valid),
    .send_is_arm      (send_is_arm),
    .send_command_id  (send_command_id),
    .busy_res         (busy_res),
    .failed_flag      (failed_flag),
    .arm_acked        (arm_acked),
    .go_connected     (go_connected),
    .retries_used     (retries_used),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #2 clk = ~clk;

  // Tracker copy and its settings
  logic        sender_on    = 1'b1;
  logic        sim_on       = 1'b0;
  logic [15:0] timeout_ms   = cart_pkg::ACK_TIMEOUT_RESET;
  logic [3:0]  resend_limit = cart_pkg::RETRY_LIMIT_RESET;

  logic        cmd_open   = 1'b0;
  logic [3:0]  open_vc    = '0;
  logic [15:0] open_id    = '0;
  logic [3:0]  resend_cnt = '0;
  logic [15:0] ms_count   = '0;
  logic        gave_up_on = 1'b0;
  logic        arm_seen   = 1'b0;

  cart_pkg::result_t pending_results[$];
  int                mismatches = 0;
  int                words_sent = 0;
  bit                quiet = 1'b0;

  function automatic logic [15:0] wire_id_for(input logic [3:0] vc);
    case (vc)
      cart_pkg::VC_ARM, cart_pkg::VC_DISARM: return cart_pkg::ID_ARM_DISARM;
      cart_pkg::VC_TAKEOFF:                  return cart_pkg::ID_TAKEOFF;
      cart_pkg::VC_AUTO:                     return cart_pkg::ID_SET_MODE;
      cart_pkg::VC_RTL:                      return cart_pkg::ID_RTL;
      cart_pkg::VC_LOITER:                   return cart_pkg::ID_LOITER;
      cart_pkg::VC_LAND:                     return cart_pkg::ID_LAND;
      default:                               return 16'd0;
    endcase
  endfunction

  function automatic cart_pkg::result_t track_word(input cart_pkg::item_t w);
    cart_pkg::result_t r;
    logic              ok;
    r  = '0;
    ok = 1'b0;
    case (w.cmd)
      cart_pkg::KIND_REQUEST: begin
        if (cmd_open) begin
          r.reject_code = cart_pkg::BR_BUSY;
        end else if (!sender_on) begin
          r.reject_code = cart_pkg::BR_NO_SENDER;
        end else if (w.failsafe) begin
          r.reject_code = cart_pkg::BR_FAILSAFE;
        end else begin
          case (w.vehicle_cmd)
            cart_pkg::VC_ARM: begin
              if (!sim_on && !w.preflight_ready) r.reject_code = cart_pkg::BR_PREFLIGHT;
              else ok = 1'b1;
            end
            // a disarm while not armed is refused without a reason
            cart_pkg::VC_DISARM: ok = w.armed;
            cart_pkg::VC_TAKEOFF: begin
              if (!w.armed) r.reject_code = cart_pkg::BR_NOT_ARMED;
              else if (!w.landed) r.reject_code = cart_pkg::BR_NOT_LANDED;
              else ok = 1'b1;
            end
            cart_pkg::VC_AUTO: ok = 1'b1;
            cart_pkg::VC_RTL, cart_pkg::VC_LOITER, cart_pkg::VC_LAND: begin
              if (!w.armed) r.reject_code = cart_pkg::BR_NOT_ARMED;
              else ok = 1'b1;
            end
            default: r.reject_code = cart_pkg::BR_UNSUPPORTED;
          endcase
        end
        if (ok) begin
          cmd_open   = 1'b1;
          open_vc    = w.vehicle_cmd;
          open_id    = wire_id_for(w.vehicle_cmd);
          resend_cnt = '0;
          ms_count   = '0;
          gave_up_on = 1'b0;
          r.request_accepted = 1'b1;
          r.send_valid       = 1'b1;
          r.send_is_arm      = (w.vehicle_cmd == cart_pkg::VC_ARM);
          r.send_command_id  = open_id;
        end
      end
      cart_pkg::KIND_ACK: begin
        if (cmd_open && w.ack_command_id == open_id) begin
          case (w.ack_result)
            cart_pkg::RES_ACCEPTED: begin
              if (open_vc == cart_pkg::VC_ARM) arm_seen = 1'b1;
              if (open_vc == cart_pkg::VC_DISARM) r.go_connected = 1'b1;
              cmd_open = 1'b0;
            end
            cart_pkg::RES_TEMP_REJECT, cart_pkg::RES_IN_PROGRESS: ;
            cart_pkg::RES_DENIED, cart_pkg::RES_UNSUPPORTED, cart_pkg::RES_FAILED: begin
              cmd_open   = 1'b0;
              gave_up_on = 1'b1;
            end
            default: cmd_open = 1'b0;
          endcase
        end
      end
      cart_pkg::KIND_TICK: begin
        if (cmd_open) begin
          if (ms_count != cart_pkg::ELAPSED_MAX) ms_count = ms_count + 16'd1;
          if (sender_on && ms_count >= timeout_ms) begin
            if (resend_cnt >= resend_limit) begin
              gave_up_on = 1'b1;
              cmd_open   = 1'b0;
            end else begin
              // resend goes out as a plain command, arm included
              resend_cnt        = resend_cnt + 4'd1;
              ms_count          = '0;
              r.send_valid      = 1'b1;
              r.send_command_id = open_id;
            end
          end
        end
      end
      default: ;
    endcase
    r.busy_res     = cmd_open;
    r.failed_flag  = gave_up_on;
    r.arm_acked    = arm_seen;
    r.retries_used = cmd_open ? resend_cnt : 4'd0;
    return r;
  endfunction

  function automatic string show(input cart_pkg::result_t r);
    return {$sformatf("acc=%0d why=%0d snd=%0d arm=%0d id=%0d ",
                      r.request_accepted, r.reject_code, r.send_valid, r.send_is_arm,
                      r.send_command_id),
            $sformatf("busy=%0d fail=%0d armack=%0d conn=%0d rtry=%0d",
                      r.busy_res, r.failed_flag, r.arm_acked,
                      r.go_connected, r.retries_used)};
  endfunction

  always @(posedge clk) begin : word_taken
    if (!rst && in_valid && !in_stall) pending_results.push_back(track_word(in_word));
  end

  always @(posedge clk) begin : result_check
    cart_pkg::result_t got;
    cart_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {request_accepted, reject_code, send_valid, send_is_arm, send_command_id,
             busy_res, failed_flag, arm_acked, go_connected, retries_used};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %s", show(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  // Hold off the result side in random bursts
  always begin : out_side
    @(posedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 19)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input cart_pkg::item_t w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  function automatic cart_pkg::item_t noise_word();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(cart_pkg::item_t)-1:0];
  endfunction

  task automatic send_request(input logic [3:0] vc, input logic [3:0] flags);
    cart_pkg::item_t w;
    w = noise_word();
    w.cmd         = cart_pkg::KIND_REQUEST;
    w.vehicle_cmd = vc;
    {w.failsafe, w.preflight_ready, w.armed, w.landed} = flags;
    send_word(w);
  endtask

  task automatic send_ack(input logic [15:0] id, input logic [7:0] res);
    cart_pkg::item_t w;
    w = noise_word();
    w.cmd            = cart_pkg::KIND_ACK;
    w.ack_command_id = id;
    w.ack_result     = res;
    send_word(w);
  endtask

  task automatic send_ticks(input int n);
    cart_pkg::item_t w;
    for (int i = 0; i < n; i++) begin
      w = noise_word();
      w.cmd = cart_pkg::KIND_TICK;
      send_word(w);
    end
  endtask

  // Drop valid and wait until every word in flight has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < SETTLE_LIMIT && pending_results.size() != 0; n++) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cart_pkg::REG_SENDER_BOUND: sender_on    = val[0];
      cart_pkg::REG_SIM_MODE:     sim_on       = val[0];
      cart_pkg::REG_ACK_TIMEOUT:  timeout_ms   = val[15:0];
      cart_pkg::REG_RETRY_LIMIT:  resend_limit = val[3:0];
      default: ;
    endcase
  endtask

  task automatic test_request_checks();
    cart_pkg::item_t w;
    send_request(cart_pkg::VC_ARM, F_ARMED | F_LANDED);
    send_request(VC_NONE, F_READY);
    send_request(VC_SET_HOME, F_READY | F_ARMED);
    send_request(VC_TOP, F_READY | F_ARMED | F_LANDED);
    send_request(cart_pkg::VC_TAKEOFF, F_FS | F_READY | F_ARMED | F_LANDED);
    send_request(cart_pkg::VC_TAKEOFF, F_LANDED);
    send_request(cart_pkg::VC_TAKEOFF, F_ARMED);
    send_request(cart_pkg::VC_LAND, F_READY);
    send_request(cart_pkg::VC_DISARM, F_LANDED);
    w     = '1;
    w.cmd = KIND_UNUSED;
    send_word(w);
    send_request(cart_pkg::VC_ARM, F_READY);
    send_request(cart_pkg::VC_RTL, F_ARMED);
    send_ack(cart_pkg::ID_ARM_DISARM + 16'd1, cart_pkg::RES_ACCEPTED);
    send_ack(cart_pkg::ID_ARM_DISARM, cart_pkg::RES_TEMP_REJECT);
    send_ack(cart_pkg::ID_ARM_DISARM, cart_pkg::RES_IN_PROGRESS);
    send_ack(cart_pkg::ID_ARM_DISARM, cart_pkg::RES_ACCEPTED);
    send_ack(cart_pkg::ID_ARM_DISARM, cart_pkg::RES_ACCEPTED);
  endtask

  task automatic test_ack_results();
    send_request(cart_pkg::VC_DISARM, F_ARMED);
    send_ack(cart_pkg::ID_ARM_DISARM, cart_pkg::RES_ACCEPTED);
    send_request(cart_pkg::VC_AUTO, 4'b0000);
    send_ack(16'hFFFF, cart_pkg::RES_ACCEPTED);
    send_ack(cart_pkg::ID_SET_MODE, cart_pkg::RES_DENIED);
    send_request(cart_pkg::VC_TAKEOFF, F_ARMED | F_LANDED);
    send_ack(cart_pkg::ID_TAKEOFF, cart_pkg::RES_UNSUPPORTED);
    send_request(cart_pkg::VC_LAND, F_ARMED);
    send_ack(cart_pkg::ID_LAND, cart_pkg::RES_FAILED);
    send_request(cart_pkg::VC_RTL, F_ARMED);
    send_ack(cart_pkg::ID_RTL, RES_CANCELLED);
    send_request(cart_pkg::VC_LOITER, F_ARMED);
    send_ack(cart_pkg::ID_LOITER, RES_WRONG_FORM_INT);
    send_request(cart_pkg::VC_RTL, F_ARMED);
    send_ack(cart_pkg::ID_RTL, RES_WRONG_FORM_FRAME);
    send_request(cart_pkg::VC_AUTO, F_FS);
    send_request(cart_pkg::VC_AUTO, F_READY);
    send_ack(cart_pkg::ID_SET_MODE, RES_TOP);
  endtask

  task automatic test_sim_mode();
    write_reg(cart_pkg::REG_SIM_MODE, 32'd1);
    send_request(cart_pkg::VC_ARM, 4'b0000);
    send_ack(cart_pkg::ID_ARM_DISARM, cart_pkg::RES_ACCEPTED);
    send_request(cart_pkg::VC_ARM, F_FS);
    write_reg(cart_pkg::REG_SIM_MODE, 32'd0);
  endtask

  task automatic test_no_sender();
    write_reg(cart_pkg::REG_ACK_TIMEOUT, 32'd2);
    send_request(cart_pkg::VC_AUTO, 4'b0000);
    write_reg(cart_pkg::REG_SENDER_BOUND, 32'd0);
    // the timer keeps running but nothing is resent
    send_request(cart_pkg::VC_RTL, F_ARMED);
    send_ticks(5);
    write_reg(cart_pkg::REG_SENDER_BOUND, 32'd1);
    send_ticks(1);
    send_ack(cart_pkg::ID_SET_MODE, cart_pkg::RES_ACCEPTED);
    write_reg(cart_pkg::REG_SENDER_BOUND, 32'd0);
    send_request(cart_pkg::VC_AUTO, F_READY);
    write_reg(cart_pkg::REG_SENDER_BOUND, 32'd1);
  endtask

  task automatic test_resend_timeout();
    // zero timeout with no resends allowed gives up on the first tick
    write_reg(cart_pkg::REG_ACK_TIMEOUT, 32'd0);
    write_reg(cart_pkg::REG_RETRY_LIMIT, 32'd0);
    send_request(cart_pkg::VC_AUTO, 4'b0000);
    send_ticks(2);
    write_reg(cart_pkg::REG_ACK_TIMEOUT, 32'd1);
    write_reg(cart_pkg::REG_RETRY_LIMIT, 32'd15);
    send_request(cart_pkg::VC_AUTO, 4'b0000);
    send_ticks(17);
    write_reg(cart_pkg::REG_ACK_TIMEOUT, 32'd3);
    write_reg(cart_pkg::REG_RETRY_LIMIT, 32'd2);
    send_request(cart_pkg::VC_ARM, F_READY);
    send_ticks(4);
    send_ack(cart_pkg::ID_ARM_DISARM, cart_pkg::RES_TEMP_REJECT);
    send_ticks(8);
  endtask

  function automatic logic [7:0] pick_result();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return cart_pkg::RES_ACCEPTED;
      4: return ($urandom_range(0, 1) != 0) ? cart_pkg::RES_TEMP_REJECT
                                            : cart_pkg::RES_IN_PROGRESS;
      5: return cart_pkg::RES_DENIED;
      6: return ($urandom_range(0, 1) != 0) ? cart_pkg::RES_UNSUPPORTED
                                            : cart_pkg::RES_FAILED;
      7: return RES_CANCELLED;
      8: return ($urandom_range(0, 1) != 0) ? RES_WRONG_FORM_INT : RES_WRONG_FORM_FRAME;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_id(input logic [15:0] last_id);
    case ($urandom_range(0, 9))
      0, 1: return wire_id_for(4'($urandom_range(1, 7)));
      2:    return 16'($urandom);
      default: return last_id;
    endcase
  endfunction

  task automatic test_random_traffic(input int phases, input int per_phase);
    int          start;
    logic [3:0]  vc;
    logic [3:0]  flags;
    logic [15:0] last_id;
    last_id = cart_pkg::ID_ARM_DISARM;
    for (int p = 0; p < phases; p++) begin
      write_reg(cart_pkg::REG_SENDER_BOUND, 32'($urandom_range(0, 3) != 0));
      write_reg(cart_pkg::REG_SIM_MODE, $urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       write_reg(cart_pkg::REG_ACK_TIMEOUT, 32'd1);
        1:       write_reg(cart_pkg::REG_ACK_TIMEOUT, 32'd65535);
        default: write_reg(cart_pkg::REG_ACK_TIMEOUT, $urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 4))
        0:       write_reg(cart_pkg::REG_RETRY_LIMIT, 32'd0);
        1:       write_reg(cart_pkg::REG_RETRY_LIMIT, 32'd15);
        default: write_reg(cart_pkg::REG_RETRY_LIMIT, $urandom_range(0, 4));
      endcase
      // keep the last phase free of idling
      quiet = (p == phases - 1);
      start = words_sent;
      while (words_sent - start < per_phase) begin
        case ($urandom_range(0, 9))
          7, 8: send_word(noise_word());
          9: send_ack(16'($urandom), 8'($urandom));
          default: begin
            vc = ($urandom_range(0, 6) != 0) ? 4'($urandom_range(1, 7)) : 4'($urandom);
            flags = {($urandom_range(0, 9) == 0), ($urandom_range(0, 4) != 0),
                     ($urandom_range(0, 4) != 0), ($urandom_range(0, 4) != 0)};
            send_request(vc, flags);
            last_id = wire_id_for(vc);
            repeat ($urandom_range(0, 4)) begin
              if ($urandom_range(0, 1) != 0) send_ticks($urandom_range(1, 10));
              else send_ack(pick_id(last_id), pick_result());
            end
          end
        endcase
      end
    end
    quiet = 1'b0;
  endtask

  initial begin : run
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_request_checks();
    test_ack_results();
    test_sim_mode();
    test_no_sender();
    test_resend_timeout();
    test_random_traffic(6, 200);
    settle();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
